[rtl/core/ttsf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsf_pkg
// Shared types, codes and the default stop word list for the tokenizer.
// ----------------------------------------------------------------------------
package ttsf_pkg;

	// input item modes
	localparam logic [1:0] MODE_TEXT = 2'd0;
	localparam logic [1:0] MODE_ADD  = 2'd1;
	localparam logic [1:0] MODE_DEL  = 2'd2;

	// register indexes
	localparam logic [2:0] REG_MIN_LENGTH  = 3'd0;
	localparam logic [2:0] REG_MAX_LENGTH  = 3'd1;
	localparam logic [2:0] REG_CASE_SENS   = 3'd2;
	localparam logic [2:0] REG_STRIP_PUNCT = 3'd3;
	localparam logic [2:0] REG_DROP_NUM    = 3'd4;

	// stored word length field, enough for lengths up to eight
	localparam int LEN_W = 4;
	localparam int DEFAULT_COUNT = 77;

	typedef enum logic [2:0] {
		ST_INIT,
		ST_IDLE,
		ST_CHECK,
		ST_EDIT_CHECK,
		ST_SCAN,
		ST_RESOLVE,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	typedef enum logic [1:0] {
		OP_TEXT,
		OP_ADD,
		OP_DEL
	} op_t;

	function automatic logic is_space(input logic [7:0] c);
		return (c == 8'd32) || (c >= 8'd9 && c <= 8'd13);
	endfunction

	function automatic logic is_punct(input logic [7:0] c);
		return (c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
			(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126);
	endfunction

	function automatic logic is_numeric(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || c == 8'h2e || c == 8'h2b || c == 8'h2d;
	endfunction

	function automatic logic [7:0] fold(input logic [7:0] c, input logic keep_case);
		if (!keep_case && c >= 8'h41 && c <= 8'h5a) begin
			return c + 8'd32;
		end
		return c;
	endfunction

	// default stop words: {length, chars packed with byte i at bits 8i}
	function automatic logic [LEN_W+39:0] default_word(input logic [6:0] idx);
		logic [LEN_W+39:0] w;
		w = '0;
		case (idx)
			7'd0:  w = {4'd1, 40'h61};
			7'd1:  w = {4'd2, 40'h6e61};
			7'd2:  w = {4'd3, 40'h646e61};
			7'd3:  w = {4'd3, 40'h657261};
			7'd4:  w = {4'd2, 40'h7361};
			7'd5:  w = {4'd2, 40'h7461};
			7'd6:  w = {4'd2, 40'h6562};
			7'd7:  w = {4'd2, 40'h7962};
			7'd8:  w = {4'd3, 40'h726f66};
			7'd9:  w = {4'd4, 40'h6d6f7266};
			7'd10: w = {4'd3, 40'h736168};
			7'd11: w = {4'd2, 40'h6568};
			7'd12: w = {4'd2, 40'h6e69};
			7'd13: w = {4'd2, 40'h7369};
			7'd14: w = {4'd2, 40'h7469};
			7'd15: w = {4'd3, 40'h737469};
			7'd16: w = {4'd2, 40'h666f};
			7'd17: w = {4'd2, 40'h6e6f};
			7'd18: w = {4'd4, 40'h74616874};
			7'd19: w = {4'd3, 40'h656874};
			7'd20: w = {4'd2, 40'h6f74};
			7'd21: w = {4'd3, 40'h736177};
			7'd22: w = {4'd4, 40'h6c6c6977};
			7'd23: w = {4'd4, 40'h68746977};
			7'd24: w = {4'd4, 40'h73696874};
			7'd25: w = {4'd3, 40'h747562};
			7'd26: w = {4'd4, 40'h79656874};
			7'd27: w = {4'd4, 40'h65766168};
			7'd28: w = {4'd3, 40'h646168};
			7'd29: w = {4'd4, 40'h74616877};
			7'd30: w = {4'd4, 40'h64696173};
			7'd31: w = {4'd4, 40'h68636165};
			7'd32: w = {4'd5, 40'h6863696877};
			7'd33: w = {4'd3, 40'h656873};
			7'd34: w = {4'd2, 40'h6f64};
			7'd35: w = {4'd3, 40'h776f68};
			7'd36: w = {4'd5, 40'h7269656874};
			7'd37: w = {4'd2, 40'h6669};
			7'd38: w = {4'd2, 40'h7075};
			7'd39: w = {4'd3, 40'h74756f};
			7'd40: w = {4'd4, 40'h796e616d};
			7'd41: w = {4'd4, 40'h6e656874};
			7'd42: w = {4'd4, 40'h6d656874};
			7'd43: w = {4'd5, 40'h6573656874};
			7'd44: w = {4'd2, 40'h6f73};
			7'd45: w = {4'd4, 40'h656d6f73};
			7'd46: w = {4'd3, 40'h726568};
			7'd47: w = {4'd5, 40'h646c756f77};
			7'd48: w = {4'd4, 40'h656b616d};
			7'd49: w = {4'd4, 40'h656b696c};
			7'd50: w = {4'd4, 40'h6f746e69};
			7'd51: w = {4'd3, 40'h6d6968};
			7'd52: w = {4'd4, 40'h656d6974};
			7'd53: w = {4'd3, 40'h6f7774};
			7'd54: w = {4'd4, 40'h65726f6d};
			7'd55: w = {4'd2, 40'h6f67};
			7'd56: w = {4'd2, 40'h6f6e};
			7'd57: w = {4'd3, 40'h796177};
			7'd58: w = {4'd5, 40'h646c756f63};
			7'd59: w = {4'd2, 40'h796d};
			7'd60: w = {4'd4, 40'h6e616874};
			7'd61: w = {4'd5, 40'h7473726966};
			7'd62: w = {4'd4, 40'h6e656562};
			7'd63: w = {4'd4, 40'h6c6c6163};
			7'd64: w = {4'd3, 40'h6f6877};
			7'd65: w = {4'd3, 40'h6c696f};
			7'd66: w = {4'd3, 40'h746973};
			7'd67: w = {4'd3, 40'h776f6e};
			7'd68: w = {4'd4, 40'h646e6966};
			7'd69: w = {4'd4, 40'h6e776f64};
			7'd70: w = {4'd3, 40'h796164};
			7'd71: w = {4'd3, 40'h646964};
			7'd72: w = {4'd3, 40'h746567};
			7'd73: w = {4'd4, 40'h656d6f63};
			7'd74: w = {4'd4, 40'h6564616d};
			7'd75: w = {4'd3, 40'h79616d};
			7'd76: w = {4'd4, 40'h74726170};
			default: w = '0;
		endcase
		return w;
	endfunction

endpackage

[rtl/core/ttsf_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ttsf_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ttsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/core/text_tokenizer_stopword_filter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_tokenizer_stopword_filter
// Whitespace tokenizer with an editable stop word table.
// ----------------------------------------------------------------------------
// A byte that ends a term adds a check state and, for terms of up to STOP_CHARS
// bytes, a lookup that reads the stop table RAM one entry a cycle; a kept term
// then leaves through the single read port of the term RAM, alternating a read
// state and a write state per byte (the read state waits while the output
// stalls). The last byte of a stop word edit adds a check state and the same
// lookup, followed by a resolve state that writes the table. After reset the
// stop table is loaded with the default list, with in_stall high;
// configuration writes are taken throughout.
module text_tokenizer_stopword_filter #(
	parameter int MAX_TERM     = 64,
	parameter int STOP_ENTRIES = 128,
	parameter int STOP_CHARS   = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  mode,
	input  logic [7:0]  in_byte,
	input  logic        in_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic        term_end,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int TA_W  = $clog2(MAX_TERM);
	localparam int CNT_W = $clog2(MAX_TERM + 2);
	localparam int IDX_W = $clog2(STOP_ENTRIES);
	localparam int SCN_W = $clog2(STOP_ENTRIES + 1);
	localparam int CW    = 8 * STOP_CHARS;
	localparam int CI_W  = $clog2(STOP_CHARS);
	localparam int LEN_W = ttsf_pkg::LEN_W;
	localparam int SW    = LEN_W + CW;

	// configuration
	logic [6:0] min_length_q, max_length_q;
	logic       case_sens_q, strip_punct_q, drop_num_q;

	ttsf_pkg::state_t state_q, state_d;
	ttsf_pkg::op_t    op_q;

	logic [CNT_W-1:0] count_q;
	logic             numeric_q;
	logic [CW-1:0]    term_word_q;
	logic [CW-1:0]    edit_word_q;
	logic [LEN_W-1:0] edit_count_q;
	logic [CW-1:0]    key_q;
	logic [LEN_W-1:0] key_len_q;

	logic [SCN_W-1:0] scan_q;
	logic             cmp_valid_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic             found_q, free_found_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [CNT_W-1:0] emit_idx_q;

	logic             out_valid_q, term_end_q;
	logic [7:0]       out_byte_q;

	// memory ports
	logic             term_we;
	logic [TA_W-1:0]  term_waddr, term_raddr;
	logic [7:0]       term_wdata, term_rdata;
	logic             stop_we;
	logic [IDX_W-1:0] stop_waddr, stop_raddr;
	logic [SW-1:0]    stop_wdata, stop_rdata;

	logic             in_xfer, out_xfer, cfg_wr;
	logic             text_kept, text_end, check_keep, check_short;
	logic [7:0]       norm_byte;
	logic [7:0]       n8;
	logic             entry_hit, entry_free;
	logic             emit_last;
	logic [LEN_W+39:0] dflt;

	assign in_xfer   = in_valid && !in_stall;
	assign out_xfer  = out_valid_q && !out_stall;
	assign cfg_wr    = psel && penable && pwrite;
	assign pready    = 1'b1;
	assign in_stall  = (state_q != ttsf_pkg::ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign term_end  = term_end_q;

	assign norm_byte = ttsf_pkg::fold(in_byte, case_sens_q);
	assign text_kept = !(strip_punct_q && ttsf_pkg::is_punct(in_byte));
	assign text_end  = ttsf_pkg::is_space(in_byte) || in_last;

	assign n8 = 8'(count_q);
	assign check_keep = (n8 != 8'd0) && (n8 >= {1'b0, min_length_q}) &&
		(n8 <= {1'b0, max_length_q}) && (n8 <= 8'(MAX_TERM)) && !(drop_num_q && numeric_q);
	assign check_short = (n8 <= 8'(STOP_CHARS));

	assign entry_hit  = cmp_valid_s1 && (stop_rdata[SW-1:CW] != '0) &&
		(stop_rdata[SW-1:CW] == key_len_q) && (stop_rdata[CW-1:0] == key_q);
	assign entry_free = cmp_valid_s1 && (stop_rdata[SW-1:CW] == '0);
	assign emit_last  = ((emit_idx_q + 1'b1) == count_q);
	// entries past the default list start out free
	assign dflt = (scan_q < SCN_W'(ttsf_pkg::DEFAULT_COUNT)) ?
		ttsf_pkg::default_word(7'(scan_q)) : '0;

	// register read
	always_comb begin
		prdata = '0;
		case (paddr[4:2])
			ttsf_pkg::REG_MIN_LENGTH:  prdata = {25'd0, min_length_q};
			ttsf_pkg::REG_MAX_LENGTH:  prdata = {25'd0, max_length_q};
			ttsf_pkg::REG_CASE_SENS:   prdata = {31'd0, case_sens_q};
			ttsf_pkg::REG_STRIP_PUNCT: prdata = {31'd0, strip_punct_q};
			ttsf_pkg::REG_DROP_NUM:    prdata = {31'd0, drop_num_q};
			default:                   prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_length_q  <= 7'd2;
			max_length_q  <= 7'd50;
			case_sens_q   <= 1'b0;
			strip_punct_q <= 1'b1;
			drop_num_q    <= 1'b0;
		end else if (cfg_wr) begin
			unique case (paddr[4:2])
				ttsf_pkg::REG_MIN_LENGTH:  min_length_q  <= pwdata[6:0];
				ttsf_pkg::REG_MAX_LENGTH:  max_length_q  <= pwdata[6:0];
				ttsf_pkg::REG_CASE_SENS:   case_sens_q   <= pwdata[0];
				ttsf_pkg::REG_STRIP_PUNCT: strip_punct_q <= pwdata[0];
				ttsf_pkg::REG_DROP_NUM:    drop_num_q    <= pwdata[0];
				default: ;
			endcase
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ttsf_pkg::ST_INIT: begin
				if (scan_q == SCN_W'(STOP_ENTRIES - 1)) state_d = ttsf_pkg::ST_IDLE;
			end
			ttsf_pkg::ST_IDLE: begin
				if (in_xfer && mode == ttsf_pkg::MODE_TEXT && text_end) begin
					state_d = ttsf_pkg::ST_CHECK;
				end else if (in_xfer && in_last &&
					(mode == ttsf_pkg::MODE_ADD || mode == ttsf_pkg::MODE_DEL)) begin
					state_d = ttsf_pkg::ST_EDIT_CHECK;
				end
			end
			ttsf_pkg::ST_CHECK: begin
				if (check_keep && check_short) state_d = ttsf_pkg::ST_SCAN;
				else if (check_keep) state_d = ttsf_pkg::ST_EMIT_RD;
				else state_d = ttsf_pkg::ST_IDLE;
			end
			ttsf_pkg::ST_EDIT_CHECK: begin
				if (edit_count_q > LEN_W'(STOP_CHARS)) state_d = ttsf_pkg::ST_IDLE;
				else state_d = ttsf_pkg::ST_SCAN;
			end
			ttsf_pkg::ST_SCAN: begin
				if (scan_q == SCN_W'(STOP_ENTRIES)) state_d = ttsf_pkg::ST_RESOLVE;
			end
			ttsf_pkg::ST_RESOLVE: begin
				if (op_q == ttsf_pkg::OP_TEXT && !found_q) state_d = ttsf_pkg::ST_EMIT_RD;
				else state_d = ttsf_pkg::ST_IDLE;
			end
			ttsf_pkg::ST_EMIT_RD: begin
				if (!out_valid_q || !out_stall) state_d = ttsf_pkg::ST_EMIT_WR;
			end
			ttsf_pkg::ST_EMIT_WR: begin
				if (emit_last) state_d = ttsf_pkg::ST_IDLE;
				else state_d = ttsf_pkg::ST_EMIT_RD;
			end
			default: state_d = ttsf_pkg::ST_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		term_we    = 1'b0;
		term_waddr = count_q[TA_W-1:0];
		term_wdata = norm_byte;
		term_raddr = emit_idx_q[TA_W-1:0];
		stop_we    = 1'b0;
		stop_waddr = scan_q[IDX_W-1:0];
		stop_wdata = '0;
		stop_raddr = scan_q[IDX_W-1:0];
		unique case (state_q)
			ttsf_pkg::ST_INIT: begin
				stop_we    = 1'b1;
				stop_wdata = {dflt[LEN_W+39:40], CW'(dflt[39:0])};
			end
			ttsf_pkg::ST_IDLE: begin
				term_we = in_xfer && mode == ttsf_pkg::MODE_TEXT &&
					!ttsf_pkg::is_space(in_byte) && text_kept && (count_q < CNT_W'(MAX_TERM));
			end
			ttsf_pkg::ST_RESOLVE: begin
				if (op_q == ttsf_pkg::OP_ADD && !found_q && free_found_q) begin
					stop_we    = 1'b1;
					stop_waddr = free_idx_q;
					stop_wdata = {key_len_q, key_q};
				end else if (op_q == ttsf_pkg::OP_DEL && found_q) begin
					stop_we    = 1'b1;
					stop_waddr = hit_idx_q;
					stop_wdata = '0;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ttsf_pkg::ST_INIT;
			op_q         <= ttsf_pkg::OP_TEXT;
			count_q      <= '0;
			numeric_q    <= 1'b1;
			term_word_q  <= '0;
			edit_word_q  <= '0;
			edit_count_q <= '0;
			scan_q       <= '0;
			cmp_valid_s1 <= 1'b0;
			found_q      <= 1'b0;
			free_found_q <= 1'b0;
			emit_idx_q   <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cmp_valid_s1 <= (state_q == ttsf_pkg::ST_SCAN) && (scan_q < SCN_W'(STOP_ENTRIES));
			if (out_xfer) out_valid_q <= 1'b0;

			unique case (state_q)
				ttsf_pkg::ST_INIT: begin
					scan_q <= (scan_q == SCN_W'(STOP_ENTRIES - 1)) ? '0 : scan_q + 1'b1;
				end
				ttsf_pkg::ST_IDLE: begin
					if (in_xfer && mode == ttsf_pkg::MODE_TEXT) begin
						op_q <= ttsf_pkg::OP_TEXT;
						if (!ttsf_pkg::is_space(in_byte) && text_kept) begin
							if (count_q < CNT_W'(STOP_CHARS)) begin
								term_word_q[8*count_q[CI_W-1:0] +: 8] <= norm_byte;
							end
							if (count_q <= CNT_W'(MAX_TERM)) count_q <= count_q + 1'b1;
							if (!ttsf_pkg::is_numeric(norm_byte)) numeric_q <= 1'b0;
						end
					end else if (in_xfer &&
						(mode == ttsf_pkg::MODE_ADD || mode == ttsf_pkg::MODE_DEL)) begin
						op_q <= (mode == ttsf_pkg::MODE_ADD) ? ttsf_pkg::OP_ADD
							: ttsf_pkg::OP_DEL;
						if (edit_count_q < LEN_W'(STOP_CHARS)) begin
							edit_word_q[8*edit_count_q[CI_W-1:0] +: 8] <= norm_byte;
						end
						if (edit_count_q <= LEN_W'(STOP_CHARS)) edit_count_q <= edit_count_q + 1'b1;
					end
				end
				ttsf_pkg::ST_CHECK: begin
					key_q        <= term_word_q;
					key_len_q    <= LEN_W'(count_q);
					scan_q       <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					emit_idx_q   <= '0;
					if (!check_keep) begin
						count_q     <= '0;
						numeric_q   <= 1'b1;
						term_word_q <= '0;
					end
				end
				ttsf_pkg::ST_EDIT_CHECK: begin
					key_q        <= edit_word_q;
					key_len_q    <= edit_count_q;
					scan_q       <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					if (edit_count_q > LEN_W'(STOP_CHARS)) begin
						edit_word_q  <= '0;
						edit_count_q <= '0;
					end
				end
				ttsf_pkg::ST_SCAN: begin
					if (scan_q < SCN_W'(STOP_ENTRIES)) scan_q <= scan_q + 1'b1;
					if (entry_hit) begin
						found_q   <= 1'b1;
						hit_idx_q <= cmp_idx_s1;
					end
					// lowest free entry wins
					if (entry_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= cmp_idx_s1;
					end
				end
				ttsf_pkg::ST_RESOLVE: begin
					emit_idx_q <= '0;
					if (op_q == ttsf_pkg::OP_TEXT) begin
						if (found_q) begin
							count_q     <= '0;
							numeric_q   <= 1'b1;
							term_word_q <= '0;
						end
					end else begin
						edit_word_q  <= '0;
						edit_count_q <= '0;
					end
				end
				ttsf_pkg::ST_EMIT_RD: ;
				ttsf_pkg::ST_EMIT_WR: begin
					out_valid_q <= 1'b1;
					emit_idx_q  <= emit_idx_q + 1'b1;
					if (emit_last) begin
						count_q     <= '0;
						numeric_q   <= 1'b1;
						term_word_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q[IDX_W-1:0];
		if (state_q == ttsf_pkg::ST_EMIT_WR) begin
			out_byte_q <= term_rdata;
			term_end_q <= emit_last;
		end
	end

	ttsf_ram #(
		.WIDTH(8),
		.DEPTH(MAX_TERM)
	) u_term_ram (
		.clk   (clk),
		.we    (term_we),
		.waddr (term_waddr),
		.wdata (term_wdata),
		.raddr (term_raddr),
		.rdata (term_rdata)
	);

	ttsf_ram #(
		.WIDTH(SW),
		.DEPTH(STOP_ENTRIES)
	) u_stop_ram (
		.clk   (clk),
		.we    (stop_we),
		.waddr (stop_waddr),
		.wdata (stop_wdata),
		.raddr (stop_raddr),
		.rdata (stop_rdata)
	);

`ifndef SYNTHESIS
	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttsf_pkg::ST_SCAN) |-> !stop_we)
		else $error("stop table written during lookup");

	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ttsf_pkg::ST_EMIT_WR) |-> (emit_idx_q < count_q))
		else $error("emit index past term length");

	a_term_end_drains: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && term_end && !out_stall) |=> !out_valid)
		else $error("byte follows term end without new term");
`endif

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the tokenizer with stop word filter: a queue-fed
// driver sends text and stop word edits, a behavioral predictor works out the
// emitted term bytes, and the monitor compares every output transfer in order.
// ----------------------------------------------------------------------------
module testbench;

	localparam int TERM_MAX   = 64;
	localparam int TABLE_SIZE = 128;
	localparam int WORD_MAX   = 8;
	localparam int DRAIN      = 2000;
	localparam int WATCH_MAX  = 20000;
	localparam int DW_W       = ttsf_pkg::LEN_W + 40;

	// mode value that the block ignores
	localparam logic [1:0] MODE_IGNORED = 2'd3;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] data;
		logic       last;
	} text_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} term_byte_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [1:0]  mode;
	logic [7:0]  in_byte;
	logic        in_last;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  out_byte;
	logic        term_end;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	text_tokenizer_stopword_filter dut (.*);

	text_item_t pending_items[$];
	term_byte_t expected_bytes[$];
	int         send_idle_pct;
	int         recv_idle_pct;
	int         error_count;
	int         quiet_cycles;

	// predictor state
	logic [6:0]  cfg_min_len;
	logic [6:0]  cfg_max_len;
	logic        cfg_keep_case;
	logic        cfg_strip;
	logic        cfg_drop_num;
	logic [7:0]  term_bytes[TERM_MAX];
	int          term_len;
	logic        term_is_num;
	logic [63:0] stop_word[TABLE_SIZE];
	int          stop_len[TABLE_SIZE];
	logic [63:0] edit_packed;
	int          edit_len;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	function automatic void add_item(text_item_t it);
		pending_items.insert(pending_items.size(), it);
	endfunction

	function automatic int stop_lookup(logic [63:0] w, int n);
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (stop_len[i] != 0 && stop_len[i] == n && stop_word[i] == w) begin
				return i;
			end
		end
		return -1;
	endfunction

	function automatic void stop_insert(logic [63:0] w, int n);
		if (n == 0 || n > WORD_MAX || stop_lookup(w, n) >= 0) begin
			return;
		end
		for (int i = 0; i < TABLE_SIZE; i++) begin
			if (stop_len[i] == 0) begin
				stop_word[i] = w;
				stop_len[i] = n;
				return;
			end
		end
	endfunction

	function automatic void close_term();
		logic [63:0] packed_term;
		logic        keep;
		int          k;
		term_byte_t  want;
		keep = !(term_len == 0 || term_len < cfg_min_len || term_len > cfg_max_len ||
			term_len > TERM_MAX);
		if (keep && term_len <= WORD_MAX) begin
			packed_term = '0;
			for (int i = 0; i < term_len; i++) begin
				packed_term |= 64'(term_bytes[i]) << (8 * i);
			end
			k = stop_lookup(packed_term, term_len);
			if (k >= 0) begin
				keep = 1'b0;
			end
		end
		if (keep && cfg_drop_num && term_is_num) begin
			keep = 1'b0;
		end
		if (keep) begin
			for (int i = 0; i < term_len; i++) begin
				want.data = term_bytes[i];
				want.last = (i == term_len - 1);
				expected_bytes.insert(expected_bytes.size(), want);
			end
		end
		term_len = 0;
		term_is_num = 1'b1;
	endfunction

	function automatic void predict_transfer(text_item_t it);
		logic [7:0] c;
		int         k;
		c = it.data;
		if (it.mode == ttsf_pkg::MODE_TEXT) begin
			if (c == 8'd32 || (c >= 8'd9 && c <= 8'd13)) begin
				close_term();
				return;
			end
			if (!(cfg_strip && ((c >= 8'd33 && c <= 8'd47) || (c >= 8'd58 && c <= 8'd64) ||
				(c >= 8'd91 && c <= 8'd96) || (c >= 8'd123 && c <= 8'd126)))) begin
				if (!cfg_keep_case && c >= "A" && c <= "Z") begin
					c = c + 8'd32;
				end
				if (term_len < TERM_MAX) begin
					term_bytes[term_len] = c;
				end
				if (term_len <= TERM_MAX) begin
					term_len++;
				end
				if (!((c >= "0" && c <= "9") || c == "." || c == "+" || c == "-")) begin
					term_is_num = 1'b0;
				end
			end
			if (it.last) begin
				close_term();
			end
		end else if (it.mode == ttsf_pkg::MODE_ADD || it.mode == ttsf_pkg::MODE_DEL) begin
			if (!cfg_keep_case && c >= "A" && c <= "Z") begin
				c = c + 8'd32;
			end
			if (edit_len < WORD_MAX) begin
				edit_packed |= 64'(c) << (8 * edit_len);
			end
			if (edit_len <= WORD_MAX) begin
				edit_len++;
			end
			if (it.last) begin
				if (it.mode == ttsf_pkg::MODE_ADD) begin
					stop_insert(edit_packed, edit_len);
				end else if (edit_len <= WORD_MAX) begin
					k = stop_lookup(edit_packed, edit_len);
					if (k >= 0) begin
						stop_word[k] = '0;
						stop_len[k] = 0;
					end
				end
				edit_packed = '0;
				edit_len = 0;
			end
		end
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
		$display("mismatch: %s got 0x%02h expected 0x%02h at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			mode <= ttsf_pkg::MODE_TEXT;
			in_byte <= '0;
			in_last <= 1'b0;
		end else if (!in_valid || !in_stall) begin
			if (pending_items.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
				in_valid <= 1'b1;
				mode <= pending_items[0].mode;
				in_byte <= pending_items[0].data;
				in_last <= pending_items[0].last;
				void'(pending_items.pop_front());
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output side, predictor hookup and watchdog
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			quiet_cycles <= 0;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
			if (in_valid && !in_stall) begin
				predict_transfer('{mode: mode, data: in_byte, last: in_last});
			end
			if (out_valid && !out_stall) begin
				if (expected_bytes.size() == 0) begin
					report_mismatch("unexpected out_byte", out_byte, 8'h00);
				end else begin
					if (out_byte !== expected_bytes[0].data) begin
						report_mismatch("out_byte", out_byte, expected_bytes[0].data);
					end
					if (term_end !== expected_bytes[0].last) begin
						report_mismatch("term_end", 8'(term_end), 8'(expected_bytes[0].last));
					end
					void'(expected_bytes.pop_front());
				end
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCH_MAX) begin
				$display("text_tokenizer_stopword_filter regression: fail");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	task automatic reg_write(logic [2:0] idx, logic [31:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= 5'(idx) << 2;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (idx)
			ttsf_pkg::REG_MIN_LENGTH:  cfg_min_len = value[6:0];
			ttsf_pkg::REG_MAX_LENGTH:  cfg_max_len = value[6:0];
			ttsf_pkg::REG_CASE_SENS:   cfg_keep_case = value[0];
			ttsf_pkg::REG_STRIP_PUNCT: cfg_strip = value[0];
			ttsf_pkg::REG_DROP_NUM:    cfg_drop_num = value[0];
			default: ;
		endcase
	endtask

	task automatic set_config(int mn, int mx, bit ks, bit sp, bit dn);
		reg_write(ttsf_pkg::REG_MIN_LENGTH, 32'(mn));
		reg_write(ttsf_pkg::REG_MAX_LENGTH, 32'(mx));
		reg_write(ttsf_pkg::REG_CASE_SENS, 32'(ks));
		reg_write(ttsf_pkg::REG_STRIP_PUNCT, 32'(sp));
		reg_write(ttsf_pkg::REG_DROP_NUM, 32'(dn));
	endtask

	task automatic push_bytes(logic [1:0] m, string s, bit last_on_end);
		for (int i = 0; i < s.len(); i++) begin
			add_item('{mode: m, data: s[i],
				last: last_on_end && (i == s.len() - 1)});
		end
	endtask

	task automatic wait_drained();
		do @(negedge clk);
		while (pending_items.size() > 0 || in_valid || expected_bytes.size() > 0);
		repeat (DRAIN) @(posedge clk);
	endtask

	// random words: mostly plain terms, some stop words, numbers, edits and noise
	task automatic random_stream(int n_items);
		logic [DW_W-1:0]              dw;
		logic [ttsf_pkg::LEN_W-1:0]   dlen;
		logic [7:0]                   c;
		logic [1:0]                   m;
		int                           len;
		int                           r;
		int                           added;
		added = 0;
		while (added < n_items) begin
			r = $urandom_range(99);
			m = (r < 12) ? ttsf_pkg::MODE_ADD : (r < 20) ? ttsf_pkg::MODE_DEL
				: ttsf_pkg::MODE_TEXT;
			if (r >= 97) begin
				add_item('{mode: MODE_IGNORED, data: 8'($urandom), last: 1'($urandom)});
				added++;
				continue;
			end
			if ($urandom_range(99) < 25) begin
				dw = ttsf_pkg::default_word(7'($urandom_range(ttsf_pkg::DEFAULT_COUNT - 1)));
				dlen = dw[DW_W-1:40];
				for (int i = 0; i < dlen; i++) begin
					c = dw[8 * i +: 8];
					if ($urandom_range(3) == 0) begin
						c = c - 8'd32;
					end
					add_item('{mode: m, data: c, last: 1'b0});
				end
				len = int'(dlen);
			end else begin
				len = ($urandom_range(19) == 0) ? $urandom_range(60, 66) : $urandom_range(1, 10);
				for (int i = 0; i < len; i++) begin
					r = $urandom_range(99);
					if (r < 50) c = 8'($urandom_range("a", "z"));
					else if (r < 60) c = 8'($urandom_range("A", "Z"));
					else if (r < 72) c = 8'($urandom_range("+", "9"));
					else if (r < 82) c = 8'($urandom_range(33, 47));
					else if (r < 92) c = 8'($urandom_range(128, 255));
					else c = 8'($urandom);
					add_item('{mode: m, data: c, last: 1'b0});
				end
			end
			added += len + 1;
			if (m != ttsf_pkg::MODE_TEXT || $urandom_range(4) == 0) begin
				pending_items[$].last = 1'b1;
				added--;
			end else begin
				r = $urandom_range(5);
				add_item('{mode: ttsf_pkg::MODE_TEXT,
					data: (r == 5) ? 8'd32 : 8'(9 + r), last: 1'($urandom_range(9) == 0)});
			end
		end
	endtask

	initial begin
		logic [DW_W-1:0] dw;
		string           s;
		error_count = 0;
		send_idle_pct = 31;
		recv_idle_pct = 57;
		arst_n = 1'b1;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		cfg_min_len = 7'd2;
		cfg_max_len = 7'd50;
		cfg_keep_case = 1'b0;
		cfg_strip = 1'b1;
		cfg_drop_num = 1'b0;
		term_len = 0;
		term_is_num = 1'b1;
		edit_packed = '0;
		edit_len = 0;
		for (int i = 0; i < TABLE_SIZE; i++) begin
			stop_word[i] = '0;
			stop_len[i] = 0;
		end
		for (int i = 0; i < ttsf_pkg::DEFAULT_COUNT; i++) begin
			dw = ttsf_pkg::default_word(7'(i));
			stop_insert(64'(dw[39:0]), int'(dw[DW_W-1:40]));
		end
		#1 arst_n = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// directed part at reset settings
		set_config(2, 50, 0, 1, 0);
		push_bytes(ttsf_pkg::MODE_TEXT, "Hi, BE the\v4.2\t", 1'b0);
		push_bytes(ttsf_pkg::MODE_TEXT, string'({"x", 8'hff, 8'h80, "\f"}), 1'b0);
		add_item('{mode: MODE_IGNORED, data: 8'h00, last: 1'b1});
		push_bytes(ttsf_pkg::MODE_ADD, "HeLLo", 1'b1);
		push_bytes(ttsf_pkg::MODE_TEXT, "HELLO ", 1'b0);
		push_bytes(ttsf_pkg::MODE_ADD, "th", 1'b0);
		push_bytes(ttsf_pkg::MODE_TEXT, "ok", 1'b0);
		push_bytes(ttsf_pkg::MODE_DEL, "e", 1'b1);
		push_bytes(ttsf_pkg::MODE_TEXT, " the.", 1'b1);
		random_stream(5);
		wait_drained();

		send_idle_pct = 57;
		recv_idle_pct = 31;
		set_config(0, 64, 1, 0, 1);
		push_bytes(ttsf_pkg::MODE_TEXT, "-1.5 Ab:c", 1'b1);
		// one byte past the term buffer: the length saturates and the term drops
		s = "";
		for (int i = 0; i < TERM_MAX + 1; i++) s = {s, "q"};
		push_bytes(ttsf_pkg::MODE_TEXT, s, 1'b1);
		random_stream(5);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		set_config(3, 8, 0, 0, 1);
		random_stream(8);
		wait_drained();

		if (error_count == 0) begin
			$display("text_tokenizer_stopword_filter regression: pass");
		end else begin
			$display("text_tokenizer_stopword_filter regression: fail");
		end
		$finish;
	end

endmodule
